// File: sv/rhcf_pkg.sv
// ----------------------------------------------------------------------------
// rhcf_pkg
// Shared types and constants for the range and heading cone filter.
// ----------------------------------------------------------------------------
package rhcf_pkg;

  localparam int MAX_LANDMARKS_DEF = 64;
  localparam int POS_BITS_DEF      = 24;

  localparam int TAG_W    = 8;
  localparam int QUAT_W   = 16;
  localparam int RADIUS_W = 20;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int QPROD_W  = 2 * QUAT_W;
  // rotation coefficients in Q6.28 (one is 2^28), range about +/-2^32
  localparam int COEF_W   = 34;

  localparam logic [RADIUS_W-1:0]      RADIUS_RESET = 20'd5120;
  localparam logic signed [COEF_W-1:0] Q_ONE_SQ     = 34'sd268435456;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF_A,
    ST_COEF_B,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic visible;
  } cone_res_t;

endpackage

// File: sv/rhcf_store.sv
// ----------------------------------------------------------------------------
// rhcf_store
// Landmark table: single write port, one registered read port.
// ----------------------------------------------------------------------------
module rhcf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 56
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/rhcf_cone.sv
// ----------------------------------------------------------------------------
// rhcf_cone
// Two-stage range and heading test on one table word per cycle while advance is high.
// ----------------------------------------------------------------------------
module rhcf_cone #(
  parameter int POS_BITS = rhcf_pkg::POS_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  advance,
  input  rhcf_pkg::pipe_ctl_t                   ctl_i,
  input  logic [2*POS_BITS+rhcf_pkg::TAG_W-1:0] entry_i,
  input  logic signed [POS_BITS-1:0]            car_x_i,
  input  logic signed [POS_BITS-1:0]            car_y_i,
  input  logic [rhcf_pkg::RADIUS_W-1:0]         radius_i,
  input  logic [rhcf_pkg::R2_W-1:0]             r2_i,
  input  logic signed [rhcf_pkg::COEF_W-1:0]    r00_i,
  input  logic signed [rhcf_pkg::COEF_W-1:0]    r10_i,
  output rhcf_pkg::cone_res_t                   res_o,
  output logic [2*POS_BITS+rhcf_pkg::TAG_W-1:0] entry_o
);

  localparam int EW   = 2 * POS_BITS + rhcf_pkg::TAG_W;
  localparam int FW_D = POS_BITS + 1;
  localparam int MW   = (FW_D > rhcf_pkg::RADIUS_W) ? FW_D : rhcf_pkg::RADIUS_W;
  // a near difference fits in radius width plus sign
  localparam int DW   = (FW_D < rhcf_pkg::RADIUS_W + 1) ? FW_D : rhcf_pkg::RADIUS_W + 1;
  localparam int SQW  = 2 * DW;
  localparam int CMPW = ((SQW + 1 > rhcf_pkg::R2_W + 1) ? SQW + 1 : rhcf_pkg::R2_W + 1);
  localparam int PW   = rhcf_pkg::COEF_W + DW;

  // difference stage
  logic signed [FW_D-1:0] dxf, dyf;
  logic [FW_D-1:0]        mag_x, mag_y;
  logic [MW-1:0]          mag_x_e, mag_y_e, rad_e;
  logic                   near;

  rhcf_pkg::pipe_ctl_t    s2_ctl_r;
  logic                   s2_near_r;
  logic signed [DW-1:0]   dx_r, dy_r;
  logic [EW-1:0]          s2_entry_r;

  // product stage
  rhcf_pkg::pipe_ctl_t    s3_ctl_r;
  logic                   s3_near_r;
  logic signed [SQW-1:0]  sq_x_r, sq_y_r;
  logic signed [PW-1:0]   fw_x_r, fw_y_r;
  logic [EW-1:0]          s3_entry_r;

  logic signed [CMPW-1:0] sq_sum, r2_e;
  logic signed [PW:0]     fw_sum;

  logic signed [POS_BITS-1:0] lx, ly;

  assign lx = entry_i[POS_BITS-1:0];
  assign ly = entry_i[2*POS_BITS-1:POS_BITS];

  always_comb begin
    dxf     = {lx[POS_BITS-1], lx} - {car_x_i[POS_BITS-1], car_x_i};
    dyf     = {ly[POS_BITS-1], ly} - {car_y_i[POS_BITS-1], car_y_i};
    mag_x   = dxf[FW_D-1] ? (~dxf + FW_D'(1)) : dxf;
    mag_y   = dyf[FW_D-1] ? (~dyf + FW_D'(1)) : dyf;
    mag_x_e = MW'(mag_x);
    mag_y_e = MW'(mag_y);
    rad_e   = MW'(radius_i);
    near    = (mag_x_e <= rad_e) && (mag_y_e <= rad_e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (advance) begin
      s2_ctl_r <= ctl_i;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_near_r  <= near;
      dx_r       <= dxf[DW-1:0];
      dy_r       <= dyf[DW-1:0];
      s2_entry_r <= entry_i;

      s3_near_r  <= s2_near_r;
      sq_x_r     <= dx_r * dx_r;
      sq_y_r     <= dy_r * dy_r;
      fw_x_r     <= r00_i * dx_r;
      fw_y_r     <= r10_i * dy_r;
      s3_entry_r <= s2_entry_r;
    end
  end

  always_comb begin
    sq_sum = {{(CMPW-SQW){sq_x_r[SQW-1]}}, sq_x_r} + {{(CMPW-SQW){sq_y_r[SQW-1]}}, sq_y_r};
    r2_e   = {{(CMPW-rhcf_pkg::R2_W){1'b0}}, r2_i};
    fw_sum = {fw_x_r[PW-1], fw_x_r} + {fw_y_r[PW-1], fw_y_r};
    res_o.valid   = s3_ctl_r.valid;
    res_o.last    = s3_ctl_r.last;
    res_o.visible = s3_near_r && (sq_sum <= r2_e) && !fw_sum[PW];
  end

  assign entry_o = s3_entry_r;

endmodule

// File: sv/range_and_heading_cone_filter_unit.sv
// ----------------------------------------------------------------------------
// range_and_heading_cone_filter_unit
// Landmark table with a range and forward-cone query over a car pose.
// ----------------------------------------------------------------------------
// Append and clear do not stall the input; a query on an empty table gives
// no result. A query on a table of N entries stalls the input until done,
// longer under output stalls: ST_COEF_A and ST_COEF_B compute the rotation
// coefficients, N reads go into a three-deep read and test pipeline, and
// ST_FLUSH sends the held final word. Reset empties the table (count zero)
// and sets the radius to 5120; table contents stay undefined until written.
module range_and_heading_cone_filter_unit #(
  parameter int MAX_LANDMARKS = rhcf_pkg::MAX_LANDMARKS_DEF,
  parameter int POS_BITS      = rhcf_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic signed [POS_BITS-1:0]          in_pos_x,
  input  logic signed [POS_BITS-1:0]          in_pos_y,
  input  logic [rhcf_pkg::TAG_W-1:0]          in_tag_in,
  input  logic signed [rhcf_pkg::QUAT_W-1:0]  in_quat_w,
  input  logic signed [rhcf_pkg::QUAT_W-1:0]  in_quat_x,
  input  logic signed [rhcf_pkg::QUAT_W-1:0]  in_quat_y,
  input  logic signed [rhcf_pkg::QUAT_W-1:0]  in_quat_z,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [POS_BITS-1:0]          out_seen_x,
  output logic signed [POS_BITS-1:0]          out_seen_y,
  output logic [rhcf_pkg::TAG_W-1:0]          out_seen_tag,
  output logic                                out_seen_valid,
  output logic                                out_last_seen,

  input  logic                                cfg_wr_en,
  input  logic [rhcf_pkg::RADIUS_W-1:0]       cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
  localparam int AW    = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int EW    = 2 * POS_BITS + rhcf_pkg::TAG_W;
  localparam int QW    = rhcf_pkg::QPROD_W;
  localparam int CW    = rhcf_pkg::COEF_W;

  rhcf_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 issue_cnt_r;
  logic [rhcf_pkg::RADIUS_W-1:0]    radius_r;
  logic signed [POS_BITS-1:0]       car_x_r, car_y_r;
  logic signed [rhcf_pkg::QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [QW-1:0]             qyy_r, qzz_r, qxy_r, qzw_r;
  logic [rhcf_pkg::R2_W-1:0]        r2_r;
  logic signed [CW-1:0]             r00_r, r10_r;
  logic signed [QW:0]               diag_sum, cross_sum;

  rhcf_pkg::pipe_ctl_t  s1_ctl_r;
  rhcf_pkg::cone_res_t  res;
  logic [EW-1:0]        rd_entry, res_entry, wr_entry;

  logic                 pend_v_r;
  logic [EW-1:0]        pend_r;

  logic                       out_valid_r, out_sv_r, out_last_r;
  logic signed [POS_BITS-1:0] out_x_r, out_y_r;
  logic [rhcf_pkg::TAG_W-1:0] out_tag_r;

  logic in_acc, advance, table_full, mem_we, issue, walk_done;
  logic push_pend, push_flush, take_res;
  logic stall_c;

  // output slot free: pipeline may move
  assign advance    = !out_valid_r || !out_stall;
  assign in_acc     = in_valid && !in_stall;
  assign table_full = (count_r >= CNT_W'(MAX_LANDMARKS));
  assign wr_entry   = {in_tag_in, in_pos_y, in_pos_x};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhcf_pkg::ST_IDLE: begin
        if (in_acc && in_operation == rhcf_pkg::OP_QUERY && count_r != '0) begin
          state_nxt = rhcf_pkg::ST_COEF_A;
        end
      end
      rhcf_pkg::ST_COEF_A: state_nxt = rhcf_pkg::ST_COEF_B;
      rhcf_pkg::ST_COEF_B: state_nxt = rhcf_pkg::ST_WALK;
      rhcf_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = rhcf_pkg::ST_FLUSH;
        end
      end
      rhcf_pkg::ST_FLUSH: begin
        if (advance) begin
          state_nxt = rhcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rhcf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    stall_c    = (state_r != rhcf_pkg::ST_IDLE);
    mem_we     = in_acc && in_operation == rhcf_pkg::OP_APPEND && !table_full;
    issue      = (state_r == rhcf_pkg::ST_WALK) && (issue_cnt_r < count_r);
    take_res   = res.valid && advance;
    walk_done  = take_res && res.last;
    push_pend  = take_res && res.visible && pend_v_r;
    push_flush = (state_r == rhcf_pkg::ST_FLUSH) && advance;
  end

  assign in_stall = stall_c;

  always_comb begin
    diag_sum  = {qyy_r[QW-1], qyy_r} + {qzz_r[QW-1], qzz_r};
    cross_sum = {qxy_r[QW-1], qxy_r} + {qzw_r[QW-1], qzw_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhcf_pkg::ST_IDLE;
      count_r     <= '0;
      radius_r    <= rhcf_pkg::RADIUS_RESET;
      issue_cnt_r <= '0;
      s1_ctl_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (in_acc) begin
        case (in_operation)
          rhcf_pkg::OP_APPEND: begin
            if (!table_full) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
          rhcf_pkg::OP_CLEAR: count_r <= '0;
          default: ;
        endcase
      end
      if (state_r == rhcf_pkg::ST_COEF_B) begin
        issue_cnt_r <= '0;
      end else if (issue && advance) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
      end
      if (advance) begin
        s1_ctl_r.valid <= issue;
        s1_ctl_r.last  <= (issue_cnt_r == count_r - CNT_W'(1));
        out_valid_r    <= push_pend || push_flush;
      end
      // hold one visible word back so the final one can carry the last flag
      if (take_res && res.visible) begin
        pend_v_r <= 1'b1;
      end else if (push_flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == rhcf_pkg::OP_QUERY) begin
      car_x_r <= in_pos_x;
      car_y_r <= in_pos_y;
      qw_r    <= in_quat_w;
      qx_r    <= in_quat_x;
      qy_r    <= in_quat_y;
      qz_r    <= in_quat_z;
    end
    if (state_r == rhcf_pkg::ST_COEF_A) begin
      qyy_r <= qy_r * qy_r;
      qzz_r <= qz_r * qz_r;
      qxy_r <= qx_r * qy_r;
      qzw_r <= qz_r * qw_r;
      r2_r  <= radius_r * radius_r;
    end
    if (state_r == rhcf_pkg::ST_COEF_B) begin
      r00_r <= rhcf_pkg::Q_ONE_SQ - {diag_sum, 1'b0};
      r10_r <= {cross_sum, 1'b0};
    end
    if (take_res && res.visible) begin
      pend_r <= res_entry;
    end
    if (push_flush) begin
      out_x_r    <= pend_v_r ? pend_r[POS_BITS-1:0] : '0;
      out_y_r    <= pend_v_r ? pend_r[2*POS_BITS-1:POS_BITS] : '0;
      out_tag_r  <= pend_v_r ? pend_r[EW-1:2*POS_BITS] : '0;
      out_sv_r   <= pend_v_r;
      out_last_r <= 1'b1;
    end else if (push_pend) begin
      out_x_r    <= pend_r[POS_BITS-1:0];
      out_y_r    <= pend_r[2*POS_BITS-1:POS_BITS];
      out_tag_r  <= pend_r[EW-1:2*POS_BITS];
      out_sv_r   <= 1'b1;
      out_last_r <= 1'b0;
    end
  end

  rhcf_store #(
    .DEPTH (MAX_LANDMARKS),
    .AW    (AW),
    .WIDTH (EW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (advance),
    .rd_addr (issue_cnt_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  rhcf_cone #(
    .POS_BITS (POS_BITS)
  ) u_cone (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .ctl_i    (s1_ctl_r),
    .entry_i  (rd_entry),
    .car_x_i  (car_x_r),
    .car_y_i  (car_y_r),
    .radius_i (radius_r),
    .r2_i     (r2_r),
    .r00_i    (r00_r),
    .r10_i    (r10_r),
    .res_o    (res),
    .entry_o  (res_entry)
  );

  assign out_valid      = out_valid_r;
  assign out_seen_x     = out_x_r;
  assign out_seen_y     = out_y_r;
  assign out_seen_tag   = out_tag_r;
  assign out_seen_valid = out_sv_r;
  assign out_last_seen  = out_last_r;

endmodule
